FILE: rtl/mhpq_pkg.sv
// Package for the max-heap priority queue core: transaction structs,
// heap slot layout and operation codes. No dependencies.
`default_nettype none

package mhpq_pkg;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam int SCORE_W = 32;
  localparam int COORD_W = 10;
  localparam int COUNT_W = 11;

  typedef struct packed {
    logic                      action;
    logic signed [SCORE_W-1:0] entry_score;
    logic [COORD_W-1:0]        entry_row;
    logic [COORD_W-1:0]        entry_column;
  } cmd_t;

  typedef struct packed {
    logic                      accepted;
    logic                      top_valid;
    logic signed [SCORE_W-1:0] top_score;
    logic [COORD_W-1:0]        top_row;
    logic [COORD_W-1:0]        top_column;
    logic [COUNT_W-1:0]        entry_count;
  } result_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        column;
  } slot_t;

endpackage

`default_nettype wire

FILE: rtl/mhpq_ram.sv
// Heap storage: one write port, one read port with registered read data.
// Depends on mhpq_pkg for the slot layout.
`default_nettype none

module mhpq_ram #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire mhpq_pkg::slot_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output mhpq_pkg::slot_t      rdata
);

  mhpq_pkg::slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/max_heap_priority_queue_core.sv
// Top level of the max-heap priority queue: command handshake, sift sequencer
// around one shared signed comparator. Depends on mhpq_pkg and mhpq_ram.
//
//   channel   ports             handshake
//   command   cmd (cmd_t)       taken at a clock edge with start high, busy low
//   result    result (result_t) done high for one cycle, cannot be stalled
//
// Busy time per command, each level bound by the single RAM read port:
// Insert climbs until a greater parent stops the climb or the root is reached.
// Remove descends until the sift stops on a compare or at a leaf.
// A refused operation runs no sift.
// The result strobes in the first idle cycle after the sequencer finishes; a
// new command may be taken in that same cycle. Reset empties the heap at once.
`default_nettype none

module max_heap_priority_queue_core #(
  parameter int CAPACITY = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire mhpq_pkg::cmd_t cmd,
  output logic                done,
  output mhpq_pkg::result_t   result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP      = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_DN_LAST = 4'd3;
  localparam logic [3:0] S_DN_LOAD = 4'd4;
  localparam logic [3:0] S_DN_CHK  = 4'd5;
  localparam logic [3:0] S_DN_LEFT = 4'd6;
  localparam logic [3:0] S_DN_RGT  = 4'd7;
  localparam logic [3:0] S_DN_CMP  = 4'd8;
  localparam logic [3:0] S_ROOT    = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  logic [3:0]      state;
  logic [CW-1:0]   count;
  logic            ok;
  logic [AW-1:0]   idx;    // hole position during a sift
  logic [AW-1:0]   kid;    // index of the larger child
  mhpq_pkg::slot_t cur;    // entry being sifted, not yet stored
  mhpq_pkg::slot_t child;

  logic            we;
  logic [AW-1:0]   waddr;
  mhpq_pkg::slot_t wdata;
  logic [AW-1:0]   raddr;
  mhpq_pkg::slot_t rdata;

  logic signed [mhpq_pkg::SCORE_W-1:0] cmp_a;
  logic signed [mhpq_pkg::SCORE_W-1:0] cmp_b;
  logic                                cmp_lt;

  logic [AW-1:0] parent;
  logic [AW:0]   left_c;
  logic [AW:0]   right_c;
  logic [AW:0]   count_x;

  assign parent  = (idx - AW'(1)) >> 1;
  assign left_c  = {idx, 1'b1};
  assign right_c = left_c + (AW+1)'(1);
  assign count_x = (AW+1)'(count);
  assign busy    = (state != S_IDLE);

  mhpq_ram #(.DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shared comparator: cmp_lt = cmp_a < cmp_b
  always_comb begin
    cmp_a = cur.score;
    cmp_b = rdata.score;
    case (state)
      S_DN_RGT: begin
        cmp_a = child.score;
        cmp_b = rdata.score;
      end
      S_DN_CMP: begin
        cmp_a = cur.score;
        cmp_b = child.score;
      end
      default: begin
        cmp_a = cur.score;
        cmp_b = rdata.score;
      end
    endcase
    cmp_lt = (cmp_a < cmp_b);
  end

  // RAM port control
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = cur;
    raddr = '0;
    case (state)
      S_UP: begin
        if (idx == '0) begin
          we = 1'b1;
        end else begin
          raddr = parent;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (!cmp_lt) begin
          wdata = rdata;
        end
      end
      S_DN_LAST: raddr = AW'(count);
      S_DN_CHK: begin
        if (left_c >= count_x) begin
          we = 1'b1;
        end else begin
          raddr = AW'(left_c);
        end
      end
      S_DN_LEFT: raddr = AW'(right_c);
      S_DN_CMP: begin
        we = 1'b1;
        if (cmp_lt) begin
          wdata = child;
        end
      end
      default: begin
        we    = 1'b0;
        raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (cmd.action == mhpq_pkg::ACT_INSERT) begin
              if (count != CW'(CAPACITY)) begin
                ok         <= 1'b1;
                cur.score  <= cmd.entry_score;
                cur.row    <= cmd.entry_row;
                cur.column <= cmd.entry_column;
                idx        <= AW'(count);
                count      <= count + CW'(1);
                state      <= S_UP;
              end else begin
                ok    <= 1'b0;
                state <= S_ROOT;
              end
            end else begin
              if (count != '0) begin
                ok    <= 1'b1;
                count <= count - CW'(1);
                state <= S_DN_LAST;
              end else begin
                ok    <= 1'b0;
                state <= S_ROOT;
              end
            end
          end
        end
        S_UP: state <= (idx == '0) ? S_ROOT : S_UP_CMP;
        S_UP_CMP: begin
          // parent strictly greater stops the climb; a tie moves up
          if (cmp_lt) begin
            state <= S_ROOT;
          end else begin
            idx   <= parent;
            state <= S_UP;
          end
        end
        S_DN_LAST: state <= S_DN_LOAD;
        S_DN_LOAD: begin
          cur   <= rdata;
          idx   <= '0;
          state <= S_DN_CHK;
        end
        S_DN_CHK: state <= (left_c >= count_x) ? S_ROOT : S_DN_LEFT;
        S_DN_LEFT: begin
          child <= rdata;
          kid   <= AW'(left_c);
          state <= (right_c < count_x) ? S_DN_RGT : S_DN_CMP;
        end
        S_DN_RGT: begin
          // right child wins only when strictly larger
          if (cmp_lt) begin
            child <= rdata;
            kid   <= kid + AW'(1);
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (cmp_lt) begin
            idx   <= kid;
            state <= S_DN_CHK;
          end else begin
            state <= S_ROOT;
          end
        end
        S_ROOT: state <= S_FIN;
        S_FIN: begin
          done               <= 1'b1;
          result.accepted    <= ok;
          result.top_valid   <= (count != '0);
          result.top_score   <= (count != '0) ? rdata.score  : '0;
          result.top_row     <= (count != '0) ? rdata.row    : '0;
          result.top_column  <= (count != '0) ? rdata.column : '0;
          result.entry_count <= mhpq_pkg::COUNT_W'(count);
          state              <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while sequencer active");

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command taken but sequencer did not start");

  a_write_busy: assert property (@(posedge clk) disable iff (rst) we |-> busy)
    else $error("heap write outside an operation");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_top_valid: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.top_valid == (count != '0)))
    else $error("top_valid disagrees with entry count");

endmodule

`default_nettype wire
